FILE: sv/assm_pkg.sv
`default_nettype none
package assm_pkg;

   // Field widths
   localparam int ANGLE_W = 15;
   localparam int RATE_W  = 18;
   localparam int PULSE_W = 12;
   localparam int DIFF_W  = 13;
   localparam int ERR_W   = 22;
   localparam int INTEG_W = 24;
   localparam int SERVO_W = 32;
   localparam int ACC_W   = 40;
   localparam int MULA_W  = 32;
   localparam int MULB_W  = 30;
   localparam int PROD_W  = MULA_W + MULB_W;
   localparam int CSR_IDX_W = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_MODE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_ROLL  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_PITCH = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_YAW   = 4'd3;

   localparam logic [PULSE_W-1:0] NEUTRAL_RESET = 12'd1500;

   // Loop limits
   localparam logic signed [24:0]      INTEG_LIM = 25'sd1600000;
   localparam logic signed [ACC_W-1:0] ROLL_LIM  = 40'sd72000000;
   localparam logic signed [ACC_W-1:0] PITCH_LIM = 40'sd25600000;

   // Pulse conversion: floor(x / 16000000) = floor(floor(x / 1024) / 15625).
   // The shifted value is clamped to where the pulse saturates anyway, biased
   // positive, and divided by 15625 through a rounded-up reciprocal (2^41 scale).
   localparam int                      CONV_SHIFT = 10;
   localparam logic signed [PROD_W-1:0] T_LO = -62'sd31250000;
   localparam logic signed [PROD_W-1:0] T_HI = 62'sd46875000;
   localparam logic signed [MULB_W-1:0] RECIP_M = 30'sd140737489;
   localparam int                      RECIP_SHIFT = 41;
   localparam logic signed [15:0]      PULSE_BIAS = 16'sd500;
   localparam logic signed [15:0]      PULSE_MAX  = 16'sd4095;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD,
      OP_ER0, OP_ER1, OP_ER2,
      OP_EP0, OP_EP1, OP_EP2,
      OP_INTEG,
      OP_SR0, OP_SR1, OP_SR2,
      OP_SP0, OP_SP1, OP_SP2,
      OP_SY0, OP_SY1,
      OP_CV0, OP_CV1, OP_CV2
   } op_type;

   typedef enum logic [2:0] {
      CH_ROLL_A, CH_ROLL_B, CH_PITCH_A, CH_PITCH_B, CH_YAW
   } chan_type;

   typedef struct packed {
      op_type   op;
      chan_type chan;
   } cmd_type;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_type;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

   // Microcode sequence of the shared multiplier datapath
   function automatic cmd_type step_cmd(input logic [STEP_W-1:0] step);
      cmd_type c;
      c.op   = OP_NOP;
      c.chan = CH_ROLL_A;
      case (step)
         5'd0:  c.op = OP_ER0;
         5'd1:  c.op = OP_ER1;
         5'd2:  c.op = OP_ER2;
         5'd3:  c.op = OP_EP0;
         5'd4:  c.op = OP_EP1;
         5'd5:  c.op = OP_EP2;
         5'd6:  c.op = OP_INTEG;
         5'd7:  c.op = OP_SR0;
         5'd8:  c.op = OP_SR1;
         5'd9:  c.op = OP_SR2;
         5'd10: c.op = OP_SP0;
         5'd11: c.op = OP_SP1;
         5'd12: c.op = OP_SP2;
         5'd13: c.op = OP_SY0;
         5'd14: c.op = OP_SY1;
         5'd15: begin c.op = OP_CV0; c.chan = CH_ROLL_A; end
         5'd16: begin c.op = OP_CV1; c.chan = CH_ROLL_A; end
         5'd17: begin c.op = OP_CV2; c.chan = CH_ROLL_A; end
         5'd18: begin c.op = OP_CV0; c.chan = CH_ROLL_B; end
         5'd19: begin c.op = OP_CV1; c.chan = CH_ROLL_B; end
         5'd20: begin c.op = OP_CV2; c.chan = CH_ROLL_B; end
         5'd21: begin c.op = OP_CV0; c.chan = CH_PITCH_A; end
         5'd22: begin c.op = OP_CV1; c.chan = CH_PITCH_A; end
         5'd23: begin c.op = OP_CV2; c.chan = CH_PITCH_A; end
         5'd24: begin c.op = OP_CV0; c.chan = CH_PITCH_B; end
         5'd25: begin c.op = OP_CV1; c.chan = CH_PITCH_B; end
         5'd26: begin c.op = OP_CV2; c.chan = CH_PITCH_B; end
         5'd27: begin c.op = OP_CV0; c.chan = CH_YAW; end
         5'd28: begin c.op = OP_CV1; c.chan = CH_YAW; end
         5'd29: begin c.op = OP_CV2; c.chan = CH_YAW; end
         default: c.op = OP_NOP;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: sv/assm_ifs.sv
`default_nettype none
interface assm_req_if;
   import assm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] roll_angle;
   logic signed [ANGLE_W-1:0] pitch_angle;
   logic signed [RATE_W-1:0]  pitch_rate;
   logic signed [RATE_W-1:0]  roll_rate;
   logic [PULSE_W-1:0]        stick_roll;
   logic [PULSE_W-1:0]        stick_pitch;
   logic [PULSE_W-1:0]        stick_throttle;
   logic [PULSE_W-1:0]        stick_yaw;
   modport source (output valid, roll_angle, pitch_angle, pitch_rate, roll_rate,
                   stick_roll, stick_pitch, stick_throttle, stick_yaw, input ready);
   modport sink (input valid, roll_angle, pitch_angle, pitch_rate, roll_rate,
                 stick_roll, stick_pitch, stick_throttle, stick_yaw, output ready);
endinterface

interface assm_rsp_if;
   import assm_pkg::*;
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] pulse_roll_a;
   logic [PULSE_W-1:0] pulse_roll_b;
   logic [PULSE_W-1:0] pulse_pitch_a;
   logic [PULSE_W-1:0] pulse_pitch_b;
   logic [PULSE_W-1:0] pulse_throttle;
   logic [PULSE_W-1:0] pulse_yaw_a;
   logic [PULSE_W-1:0] pulse_yaw_b;
   modport source (output valid, pulse_roll_a, pulse_roll_b, pulse_pitch_a,
                   pulse_pitch_b, pulse_throttle, pulse_yaw_a, pulse_yaw_b, input ready);
   modport sink (input valid, pulse_roll_a, pulse_roll_b, pulse_pitch_a,
                 pulse_pitch_b, pulse_throttle, pulse_yaw_a, pulse_yaw_b, output ready);
endinterface

interface assm_csr_if;
   import assm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PULSE_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/assm_ctrl.sv
`default_nettype none
module assm_ctrl
   import assm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.op    = OP_NOP;
      cmd.chan  = CH_ROLL_A;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd     = step_cmd(step_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/assm_datapath.sv
`default_nettype none
module assm_datapath
   import assm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   input  wire logic                      csr_write,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [PULSE_W-1:0]        csr_data,
   input  wire logic signed [ANGLE_W-1:0] roll_angle,
   input  wire logic signed [ANGLE_W-1:0] pitch_angle,
   input  wire logic signed [RATE_W-1:0]  pitch_rate,
   input  wire logic signed [RATE_W-1:0]  roll_rate,
   input  wire logic [PULSE_W-1:0]        stick_roll,
   input  wire logic [PULSE_W-1:0]        stick_pitch,
   input  wire logic [PULSE_W-1:0]        stick_throttle,
   input  wire logic [PULSE_W-1:0]        stick_yaw,
   output logic [PULSE_W-1:0]             pulse_roll_a,
   output logic [PULSE_W-1:0]             pulse_roll_b,
   output logic [PULSE_W-1:0]             pulse_pitch_a,
   output logic [PULSE_W-1:0]             pulse_pitch_b,
   output logic [PULSE_W-1:0]             pulse_throttle,
   output logic [PULSE_W-1:0]             pulse_yaw
);

   // Configuration
   logic               mode_ff;
   logic [PULSE_W-1:0] nroll_ff, npitch_ff, nyaw_ff;

   // Captured item
   logic signed [DIFF_W-1:0]  droll_ff, droll_in, dpitch_ff, dpitch_in, dyaw_ff, dyaw_in;
   logic signed [ANGLE_W-1:0] roll_ff, roll_in, pitch_ff, pitch_in;
   logic signed [RATE_W-1:0]  prate_ff, prate_in, rrate_ff, rrate_in;
   logic [PULSE_W-1:0]        thr_ff, thr_in;

   // Working registers
   logic signed [ERR_W-1:0]   er_ff, er_in, ep_ff, ep_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [SERVO_W-1:0] sroll_ff, sroll_in, spitch_ff, spitch_in, syaw_ff, syaw_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [PULSE_W-1:0]        pra_ff, pra_in, prb_ff, prb_in;
   logic [PULSE_W-1:0]        ppa_ff, ppa_in, ppb_ff, ppb_in, pyaw_ff, pyaw_in;

   // Combinational helpers
   logic signed [MULA_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [ACC_W-1:0]  prod40, sum40;
   logic signed [24:0]       integ_sum;
   logic signed [SERVO_W-1:0] sel_s;
   logic                     reversed;
   logic signed [PROD_W-1:0] t_val, t_clamp;
   logic [13:0]              quot;
   logic signed [15:0]       offset, pulse_raw;
   logic [PULSE_W-1:0]       pulse_sat;

   // Configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         nroll_ff  <= NEUTRAL_RESET;
         npitch_ff <= NEUTRAL_RESET;
         nyaw_ff   <= NEUTRAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CONTROL_MODE:  mode_ff   <= csr_data[0];
            REG_NEUTRAL_ROLL:  nroll_ff  <= csr_data;
            REG_NEUTRAL_PITCH: npitch_ff <= csr_data;
            REG_NEUTRAL_YAW:   nyaw_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Shared multiplier
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod40  = prod_ff[ACC_W-1:0];
   assign sum40   = acc_ff + prod40;
   assign integ_sum = 25'(integ_ff) + 25'(ep_ff);

   // Conversion helpers
   always_comb begin
      reversed = (cmd.chan == CH_ROLL_B) || (cmd.chan == CH_PITCH_A);
      case (cmd.chan)
         CH_ROLL_A, CH_ROLL_B:   sel_s = sroll_ff;
         CH_PITCH_A, CH_PITCH_B: sel_s = spitch_ff;
         CH_YAW:                 sel_s = syaw_ff;
         default:                sel_s = syaw_ff;
      endcase
      case (cmd.chan)
         CH_PITCH_A: offset = 16'sd100;
         CH_PITCH_B: offset = 16'sd120;
         default:    offset = 16'sd0;
      endcase
      t_val = prod_ff >>> CONV_SHIFT;
      if (t_val < T_LO) begin
         t_clamp = T_LO;
      end else if (t_val > T_HI) begin
         t_clamp = T_HI;
      end else begin
         t_clamp = t_val;
      end
      quot      = prod_ff[RECIP_SHIFT+13:RECIP_SHIFT];
      pulse_raw = $signed({2'b00, quot}) - PULSE_BIAS + offset;
      if (pulse_raw < 16'sd0) begin
         pulse_sat = '0;
      end else if (pulse_raw > PULSE_MAX) begin
         pulse_sat = PULSE_MAX[PULSE_W-1:0];
      end else begin
         pulse_sat = pulse_raw[PULSE_W-1:0];
      end
   end

   // Step decode
   always_comb begin
      droll_in  = droll_ff;
      dpitch_in = dpitch_ff;
      dyaw_in   = dyaw_ff;
      roll_in   = roll_ff;
      pitch_in  = pitch_ff;
      prate_in  = prate_ff;
      rrate_in  = rrate_ff;
      thr_in    = thr_ff;
      er_in     = er_ff;
      ep_in     = ep_ff;
      integ_in  = integ_ff;
      sroll_in  = sroll_ff;
      spitch_in = spitch_ff;
      syaw_in   = syaw_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      pra_in    = pra_ff;
      prb_in    = prb_ff;
      ppa_in    = ppa_ff;
      ppb_in    = ppb_ff;
      pyaw_in   = pyaw_ff;
      mul_a     = '0;
      mul_b     = '0;
      case (cmd.op)
         OP_LOAD: begin
            droll_in  = $signed(DIFF_W'({1'b0, stick_roll}) - DIFF_W'({1'b0, nroll_ff}));
            dpitch_in = $signed(DIFF_W'({1'b0, stick_pitch}) - DIFF_W'({1'b0, npitch_ff}));
            dyaw_in   = $signed(DIFF_W'({1'b0, stick_yaw}) - DIFF_W'({1'b0, nyaw_ff}));
            roll_in   = roll_angle;
            pitch_in  = pitch_angle;
            prate_in  = pitch_rate;
            rrate_in  = roll_rate;
            thr_in    = stick_throttle;
         end
         OP_ER0: begin
            mul_a = MULA_W'(droll_ff);
            mul_b = 30'sd144;
            prod_in = product;
         end
         OP_ER1: begin
            acc_in = prod40;
            mul_a  = MULA_W'(roll_ff);
            mul_b  = mode_ff ? -30'sd25 : 30'sd0;
            prod_in = product;
         end
         OP_ER2: er_in = ERR_W'(sum40);
         OP_EP0: begin
            mul_a = MULA_W'(dpitch_ff);
            mul_b = 30'sd96;
            prod_in = product;
         end
         OP_EP1: begin
            acc_in = prod40;
            mul_a  = MULA_W'(pitch_ff);
            mul_b  = mode_ff ? -30'sd25 : 30'sd0;
            prod_in = product;
         end
         OP_EP2: ep_in = ERR_W'(sum40);
         // Accumulate and clamp the pitch error, held in manual mode
         OP_INTEG: begin
            if (mode_ff) begin
               if (integ_sum > INTEG_LIM) begin
                  integ_in = INTEG_W'(INTEG_LIM);
               end else if (integ_sum < -INTEG_LIM) begin
                  integ_in = INTEG_W'(-INTEG_LIM);
               end else begin
                  integ_in = INTEG_W'(integ_sum);
               end
            end
         end
         OP_SR0: begin
            mul_a = MULA_W'(er_ff);
            mul_b = 30'sd1000;
            prod_in = product;
         end
         OP_SR1: begin
            acc_in = prod40;
            mul_a  = MULA_W'(rrate_ff);
            mul_b  = mode_ff ? -30'sd5000 : 30'sd0;
            prod_in = product;
         end
         OP_SR2: begin
            if (mode_ff && sum40 > ROLL_LIM) begin
               sroll_in = SERVO_W'(ROLL_LIM);
            end else if (mode_ff && sum40 < -ROLL_LIM) begin
               sroll_in = SERVO_W'(-ROLL_LIM);
            end else begin
               sroll_in = SERVO_W'(sum40);
            end
         end
         OP_SP0: begin
            mul_a = MULA_W'(ep_ff);
            mul_b = mode_ff ? 30'sd2000 : 30'sd500;
            prod_in = product;
         end
         OP_SP1: begin
            acc_in = prod40 + (mode_ff ? ACC_W'(integ_ff) : '0);
            mul_a  = MULA_W'(prate_ff);
            mul_b  = mode_ff ? -30'sd25000 : 30'sd0;
            prod_in = product;
         end
         OP_SP2: begin
            if (mode_ff && sum40 > PITCH_LIM) begin
               spitch_in = SERVO_W'(PITCH_LIM);
            end else if (mode_ff && sum40 < -PITCH_LIM) begin
               spitch_in = SERVO_W'(-PITCH_LIM);
            end else begin
               spitch_in = SERVO_W'(sum40);
            end
         end
         OP_SY0: begin
            mul_a = MULA_W'(dyaw_ff);
            mul_b = 30'sd24000;
            prod_in = product;
         end
         OP_SY1: syaw_in = SERVO_W'(prod40);
         // Scale the servo angle, direction by sign
         OP_CV0: begin
            mul_a = sel_s;
            mul_b = reversed ? -30'sd111 : 30'sd111;
            prod_in = product;
         end
         // Divide by 15625 through the reciprocal
         OP_CV1: begin
            mul_a = MULA_W'(t_clamp - T_LO);
            mul_b = RECIP_M;
            prod_in = product;
         end
         OP_CV2: begin
            case (cmd.chan)
               CH_ROLL_A:  pra_in  = pulse_sat;
               CH_ROLL_B:  prb_in  = pulse_sat;
               CH_PITCH_A: ppa_in  = pulse_sat;
               CH_PITCH_B: ppb_in  = pulse_sat;
               CH_YAW:     pyaw_in = pulse_sat;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Integral state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      droll_ff  <= droll_in;
      dpitch_ff <= dpitch_in;
      dyaw_ff   <= dyaw_in;
      roll_ff   <= roll_in;
      pitch_ff  <= pitch_in;
      prate_ff  <= prate_in;
      rrate_ff  <= rrate_in;
      thr_ff    <= thr_in;
      er_ff     <= er_in;
      ep_ff     <= ep_in;
      sroll_ff  <= sroll_in;
      spitch_ff <= spitch_in;
      syaw_ff   <= syaw_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      pra_ff    <= pra_in;
      prb_ff    <= prb_in;
      ppa_ff    <= ppa_in;
      ppb_ff    <= ppb_in;
      pyaw_ff   <= pyaw_in;
   end

   assign pulse_roll_a   = pra_ff;
   assign pulse_roll_b   = prb_ff;
   assign pulse_pitch_a  = ppa_ff;
   assign pulse_pitch_b  = ppb_ff;
   assign pulse_throttle = thr_ff;
   assign pulse_yaw      = pyaw_ff;

endmodule
`default_nettype wire

FILE: sv/attitude_stabilizer_servo_mixer.sv
`default_nettype none
// Attitude stabilizer and servo mixer. One control tick is taken at a time:
// after the input transfer, a sequencer drives 30 steps through a single
// shared multiplier (error terms, pitch integral, roll and pitch laws, yaw,
// then three steps per servo pulse conversion), and the result is held on
// the output until its transfer. The result is valid after the last step,
// and the next item is taken in the cycle after the result transfer.
// Configuration writes are taken in every cycle; change the registers only
// between ticks, and they apply from the next tick on.
module attitude_stabilizer_servo_mixer
   import assm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   assm_req_if.sink   req_chan,
   assm_rsp_if.source rsp_chan,
   assm_csr_if.sink   csr_chan
);

   cmd_type cmd;
   logic    req_ready;
   logic    rsp_valid;
   logic [PULSE_W-1:0] pulse_yaw;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   assm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   assm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_write      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .roll_angle     (req_chan.roll_angle),
      .pitch_angle    (req_chan.pitch_angle),
      .pitch_rate     (req_chan.pitch_rate),
      .roll_rate      (req_chan.roll_rate),
      .stick_roll     (req_chan.stick_roll),
      .stick_pitch    (req_chan.stick_pitch),
      .stick_throttle (req_chan.stick_throttle),
      .stick_yaw      (req_chan.stick_yaw),
      .pulse_roll_a   (rsp_chan.pulse_roll_a),
      .pulse_roll_b   (rsp_chan.pulse_roll_b),
      .pulse_pitch_a  (rsp_chan.pulse_pitch_a),
      .pulse_pitch_b  (rsp_chan.pulse_pitch_b),
      .pulse_throttle (rsp_chan.pulse_throttle),
      .pulse_yaw      (pulse_yaw)
   );

   assign rsp_chan.pulse_yaw_a = pulse_yaw;
   assign rsp_chan.pulse_yaw_b = pulse_yaw;

`ifndef SYNTHESIS
   // One tick in flight: no input transfer while a result is offered
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");

   // A new tick never shows a result in the cycle after its transfer
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !rsp_valid) else $error("result too early");

   // The final yaw conversion step is followed by the result
   a_result_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CV2 && cmd.chan == CH_YAW) |=> rsp_valid)
      else $error("result missing after last step");
`endif

endmodule
`default_nettype wire
